### design/amrb_pkg.sv
// Shared types and constants of the azimuth min-range binner.
// Used by the sequencer, the bin RAM users and the top level; no dependencies.
package amrb_pkg;

	localparam int unsigned NUM_BINS_DEF = 36000;
	localparam logic [4:0]  BEAM_RESET   = 5'd15;

	localparam int unsigned DIST_W  = 16;
	localparam int unsigned LEVEL_W = 8;
	// bin word: {valid, range, level}
	localparam int unsigned WORD_W  = 1 + DIST_W + LEVEL_W;

	typedef enum logic [1:0] {
		REQ_ACCUM = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic wipe_we;
		logic exec_fire;
	} ctrl_t;

endpackage

### design/amrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module amrb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### design/amrb_seq.sv
// Sequencer of the binner: wipe sweep over the bin RAM, idle, execute held until the output is free.
// Depends on amrb_pkg.
module amrb_seq #(
	parameter int unsigned NUM_BINS = amrb_pkg::NUM_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_fire,
	input  logic                        in_clear,
	input  logic                        out_free,
	output amrb_pkg::ctrl_t             ctrl,
	output logic [$clog2(NUM_BINS)-1:0] wipe_addr
);

	localparam int unsigned AW = $clog2(NUM_BINS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

	amrb_pkg::state_t state_q, state_d;
	logic [AW-1:0] cnt_q;
	logic          pend_q;
	logic          sweep_last;

	assign sweep_last = (cnt_q == LAST_ADDR);
	assign wipe_addr  = cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			amrb_pkg::ST_SWEEP: begin
				if (sweep_last) begin
					state_d = pend_q ? amrb_pkg::ST_EXEC : amrb_pkg::ST_IDLE;
				end
			end
			amrb_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = in_clear ? amrb_pkg::ST_SWEEP : amrb_pkg::ST_EXEC;
				end
			end
			amrb_pkg::ST_EXEC: begin
				if (out_free) begin
					state_d = amrb_pkg::ST_IDLE;
				end
			end
			default: state_d = amrb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			amrb_pkg::ST_SWEEP: ctrl.wipe_we   = 1'b1;
			amrb_pkg::ST_IDLE:  ctrl.in_ready  = 1'b1;
			amrb_pkg::ST_EXEC:  ctrl.exec_fire = out_free;
			default: ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amrb_pkg::ST_SWEEP;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == amrb_pkg::ST_SWEEP) begin
				cnt_q <= sweep_last ? '0 : cnt_q + 1'b1;
				if (sweep_last) begin
					pend_q <= 1'b0;
				end
			end else if (in_fire && in_clear) begin
				pend_q <= 1'b1;
			end
		end
	end

endmodule

### design/azimuth_min_range_binner_unit.sv
// Top level of the azimuth min-range binner: stream ports, bin RAM, statistics.
// Depends on amrb_pkg, amrb_ram and amrb_seq.
//
// channel  | signals                         | payload
// ---------+---------------------------------+-------------------------------------------
// input    | s_tvalid s_tready s_tdata s_tuser | tuser req_type; tdata point / bin index
// output   | m_tvalid m_tready m_tdata        | bin fields, statistics, dropped flag
// config   | cfg_valid cfg_ready cfg_data     | beam_select
//
// A point, read or no-op request is accepted (bin RAM read) and then executed
// (compare, write back, result). A clear first wipes the bin RAM, one entry per
// cycle, and then executes; reset runs the same wipe with s_tready low. While the
// output register is full and not taken, execute holds.
module azimuth_min_range_binner_unit #(
	parameter int unsigned NUM_BINS = amrb_pkg::NUM_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // laser_id[4:0] azimuth[20:5] distance[36:21]
	                               // intensity[44:37], zero [47:45]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // bin_filled[0] bin_distance[16:1] bin_intensity[24:17]
	                               // any_point[25] scan_min[41:26] scan_max[57:42]
	                               // dropped[58], zero [63:59]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // beam_select[4:0]
);

	localparam int unsigned AW = $clog2(NUM_BINS);
	localparam int unsigned WW = amrb_pkg::WORD_W;
	localparam int unsigned DW = amrb_pkg::DIST_W;
	localparam int unsigned LW = amrb_pkg::LEVEL_W;
	localparam logic [16:0] BIN_LIMIT = 17'(NUM_BINS);

	amrb_pkg::ctrl_t ctrl;
	logic [AW-1:0]   wipe_addr;
	logic            in_fire, in_clear, out_free;

	logic [4:0]      beam_q;
	amrb_pkg::req_t  req_q;
	logic [4:0]      lid_q;
	logic [15:0]     az_q;
	logic [DW-1:0]   dist_q;
	logic [LW-1:0]   inten_q;

	logic [DW-1:0]   min_q, max_q;
	logic            seen_q;

	logic            out_valid_q;
	logic [63:0]     out_data_q;

	logic [15:0]     s_az;
	logic            s_in_rng;
	logic [AW-1:0]   rd_addr;
	logic [WW-1:0]   rd_word, wr_word;
	logic            ram_we;
	logic [AW-1:0]   ram_wr_addr;

	logic            old_v;
	logic [DW-1:0]   old_r;
	logic [LW-1:0]   old_l;
	logic            hit, in_rng, upd, take;
	logic [DW-1:0]   min_d, max_d;
	logic            seen_d;
	logic            r_filled, r_drop;
	logic [DW-1:0]   r_dist;
	logic [LW-1:0]   r_inten;

	assign s_tready  = ctrl.in_ready;
	assign cfg_ready = 1'b1;
	assign in_fire   = s_tvalid && ctrl.in_ready;
	assign in_clear  = (amrb_pkg::req_t'(s_tuser) == amrb_pkg::REQ_CLEAR);
	assign out_free  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	amrb_seq #(
		.NUM_BINS(NUM_BINS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_clear (in_clear),
		.out_free (out_free),
		.ctrl     (ctrl),
		.wipe_addr(wipe_addr)
	);

	// read the addressed bin in the accept cycle
	assign s_az     = s_tdata[20:5];
	assign s_in_rng = ({1'b0, s_az} < BIN_LIMIT);
	assign rd_addr  = s_in_rng ? s_az[AW-1:0] : '0;

	amrb_ram #(
		.WIDTH(WW),
		.DEPTH(NUM_BINS)
	) u_bins (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(wr_word),
		.rd_en  (in_fire),
		.rd_addr(rd_addr),
		.rd_data(rd_word)
	);

	assign old_v = rd_word[WW-1];
	assign old_r = rd_word[LW +: DW];
	assign old_l = rd_word[LW-1:0];

	assign hit    = (req_q == amrb_pkg::REQ_ACCUM) && (lid_q == beam_q);
	assign in_rng = ({1'b0, az_q} < BIN_LIMIT);
	assign take   = hit && in_rng;
	assign upd    = take && (!old_v || (dist_q < old_r));

	assign ram_we      = ctrl.wipe_we || (ctrl.exec_fire && upd);
	assign ram_wr_addr = ctrl.wipe_we ? wipe_addr : az_q[AW-1:0];
	assign wr_word     = ctrl.wipe_we ? '0 : {1'b1, dist_q, inten_q};

	assign min_d  = (take && (dist_q < min_q)) ? dist_q : min_q;
	assign max_d  = (take && (dist_q > max_q)) ? dist_q : max_q;
	assign seen_d = seen_q || take;

	always_comb begin
		r_filled = 1'b0;
		r_dist   = '0;
		r_inten  = '0;
		r_drop   = 1'b0;
		unique case (req_q) inside
			amrb_pkg::REQ_ACCUM: begin
				if (hit) begin
					if (!in_rng) begin
						r_drop = 1'b1;
					end else begin
						r_filled = 1'b1;
						r_dist   = upd ? dist_q : old_r;
						r_inten  = upd ? inten_q : old_l;
					end
				end
			end
			amrb_pkg::REQ_READ: begin
				if (!in_rng) begin
					r_drop = 1'b1;
				end else if (old_v) begin
					r_filled = 1'b1;
					r_dist   = old_r;
					r_inten  = old_l;
				end
			end
			amrb_pkg::REQ_CLEAR, amrb_pkg::REQ_NOP: begin
				r_drop = 1'b0;
			end
			default: r_drop = 1'b0;
		endcase
	end

	// hold the request while it executes
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q   <= amrb_pkg::req_t'(s_tuser);
			lid_q   <= s_tdata[4:0];
			az_q    <= s_az;
			dist_q  <= s_tdata[36:21];
			inten_q <= s_tdata[44:37];
		end
		if (ctrl.exec_fire) begin
			out_data_q <= {5'd0, r_drop, max_d, min_d, seen_d, r_inten, r_dist, r_filled};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q      <= amrb_pkg::BEAM_RESET;
			min_q       <= '1;
			max_q       <= '0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				beam_q <= cfg_data;
			end
			if (in_fire && in_clear) begin
				min_q  <= '1;
				max_q  <= '0;
				seen_q <= 1'b0;
			end else if (ctrl.exec_fire) begin
				min_q  <= min_d;
				max_q  <= max_d;
				seen_q <= seen_d;
			end
			if (ctrl.exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### design/amrb_checker.sv
// Port-level checks of the binner result stream, bound to the top level.
// Depends on azimuth_min_range_binner_unit.
module amrb_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata
);

	// a pending result transaction stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before it was taken");

	// with no point since clear, statistics sit at their cleared values
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[25] |-> (m_tdata[41:26] == 16'hFFFF) && (m_tdata[57:42] == 16'd0))
		else $error("statistics not at cleared values");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[25] |-> (m_tdata[41:26] <= m_tdata[57:42]))
		else $error("scan minimum above scan maximum");

	// an empty or dropped bin shows zero fields
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[24:1] == 24'd0))
		else $error("empty bin with nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[58] |-> !m_tdata[0])
		else $error("dropped transaction shows a filled bin");

endmodule

bind azimuth_min_range_binner_unit amrb_port_checks u_amrb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
